>>> sv/cma_pkg.sv
// Shared types and fixed constants for the centered moving average block.
package cma_pkg;

    localparam int WIN_BITS = 6;
    localparam int OUT_BITS = 24;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 6'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

endpackage

>>> sv/centered_moving_average.sv
// Top level of the centered moving average with shrinking edge windows.
//
// Input channel (i_in_valid / o_in_ready) carries one signed sample and a
// last flag per item. Output channel (o_out_valid / i_out_ready) carries
// one window mean (FRAC_BITS fraction bits, floored) and a final_res flag.
// Output i is the mean of samples i-h..i+h with h the smaller of the
// configured half-width and the distances to both record edges.
// An ordinary sample yields at most one result, once hw later samples have
// come in; a sample flagged last flushes every pending result of the record,
// the final one marked with final_res.
// One item is processed at a time. Each result costs 2h+1 ring reads
// followed by a bit-serial division and the control states. The single-port
// ring and the bit-serial divider set this cost; a flush pays it per result.
// The output register lets a finished result wait while the next one is
// worked on; when the receiver stalls, work stops with the next result
// ready until the held one is taken.
// Synchronous reset clears counters and the result valid flag and sets the
// window register to 5; the sample ring needs no clearing, since a mean
// only reads samples of the current record.
module centered_moving_average #(
    parameter int MAX_WINDOW  = 63,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cma_pkg::WIN_BITS-1:0]     i_window_size,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  logic                             i_last,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [cma_pkg::OUT_BITS-1:0] o_average,
    output logic                             o_final_res
);

    import cma_pkg::*;

    localparam int RING_DEPTH = MAX_WINDOW + 1;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SUM_W      = SAMPLE_BITS + PTR_W;
    localparam int NUM_W      = SUM_W + FRAC_BITS;
    localparam int CMW        = ((PTR_W > WIN_BITS) ? PTR_W : WIN_BITS) + 1;

    // sample ring, one write on item acceptance, one registered read
    logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
    logic                   mem_we;
    logic [SAMPLE_BITS-1:0] r_rd_data;

    t_state                 r_state, n_state;
    logic [WIN_BITS-1:0]    r_window, n_window;
    logic [PTR_W-1:0]       r_wp, n_wp;
    logic [PTR_W-1:0]       r_m, n_m;
    logic [PTR_W-1:0]       r_newest, n_newest;
    logic [PTR_W-1:0]       r_jm, n_jm;
    logic [PTR_W-1:0]       r_c, n_c;
    logic                   r_flush, n_flush;
    logic [PTR_W-1:0]       r_h, n_h;
    logic [PTR_W-1:0]       r_left, n_left;
    logic [PTR_W-1:0]       r_addr, n_addr;
    logic                   r_rd_vld, n_rd_vld;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                   r_out_valid, n_out_valid;
    logic signed [OUT_BITS-1:0] r_average, n_average;
    logic                   r_final, n_final;

    logic [CMW-1:0]         w_ext;
    logic [CMW-1:0]         w_clip;
    logic [CMW-1:0]         w_odd;
    logic [CMW-1:0]         hw_full;
    logic [PTR_W-1:0]       hw;
    logic [PTR_W-1:0]       m_minus_c;
    logic [PTR_W-1:0]       h_calc;
    logic [PTR_W-1:0]       off;
    logic [PTR_W-1:0]       start_addr;

    logic                   div_start;
    logic                   div_done;
    logic signed [NUM_W-1:0] div_num;
    logic signed [NUM_W-1:0] div_q;

    // effective half-width: clamp, force odd, stay within MAX_WINDOW
    always_comb begin
        w_ext  = CMW'(r_window);
        w_clip = (w_ext > CMW'(MAX_WINDOW)) ? CMW'(MAX_WINDOW) : w_ext;
        w_odd  = w_clip | CMW'(1);
        if (w_odd > CMW'(MAX_WINDOW)) begin
            w_odd = w_odd - CMW'(2);
        end
        hw_full = w_odd >> 1;
        hw      = hw_full[PTR_W-1:0];
    end

    // half-width of the current job: distance to record start or end
    always_comb begin
        m_minus_c  = r_jm - r_c;
        h_calc     = (m_minus_c < r_c) ? m_minus_c : r_c;
        off        = r_c - h_calc;
        start_addr = (r_newest >= off) ? (r_newest - off)
                   : PTR_W'(({1'b0, r_newest} + (PTR_W+1)'(RING_DEPTH)) - {1'b0, off});
    end

    assign div_num = NUM_W'(r_sum) <<< FRAC_BITS;

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_wp        = r_wp;
        n_m         = r_m;
        n_newest    = r_newest;
        n_jm        = r_jm;
        n_c         = r_c;
        n_flush     = r_flush;
        n_h         = r_h;
        n_left      = r_left;
        n_addr      = r_addr;
        n_rd_vld    = 1'b0;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_average   = r_average;
        n_final     = r_final;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        o_in_ready  = (r_state == S_IDLE);

        if (i_cfg_we) begin
            n_window = i_window_size;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    mem_we   = 1'b1;
                    n_newest = r_wp;
                    n_jm     = r_m;
                    n_flush  = i_last;
                    if (i_last) begin
                        // flush: start with the oldest pending center
                        n_c     = (r_m < hw) ? r_m : hw;
                        n_m     = '0;
                        n_wp    = '0;
                        n_state = S_SETUP;
                    end else begin
                        n_c  = hw;
                        n_m  = (r_m == PTR_W'(MAX_WINDOW)) ? r_m : r_m + 1'b1;
                        n_wp = (r_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_m >= hw) begin
                            n_state = S_SETUP;
                        end
                    end
                end
            end
            S_SETUP: begin
                n_h     = h_calc;
                n_left  = PTR_W'({h_calc, 1'b1});
                n_addr  = start_addr;
                n_sum   = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                // walk back through the window, one read a cycle
                if (r_left != '0) begin
                    n_addr   = (r_addr == '0) ? PTR_W'(RING_DEPTH - 1) : r_addr - 1'b1;
                    n_left   = r_left - 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    n_sum = r_sum + SUM_W'(signed'(r_rd_data));
                end
                if (r_left == '0 && !r_rd_vld) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_average   = OUT_BITS'(div_q);
                    n_final     = r_flush && (r_c == '0);
                    if (r_flush && (r_c != '0)) begin
                        n_c     = r_c - 1'b1;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WIN_RESET;
            r_wp        <= '0;
            r_m         <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_wp        <= n_wp;
            r_m         <= n_m;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_newest  <= n_newest;
        r_jm      <= n_jm;
        r_c       <= n_c;
        r_flush   <= n_flush;
        r_h       <= n_h;
        r_left    <= n_left;
        r_addr    <= n_addr;
        r_sum     <= n_sum;
        r_average <= n_average;
        r_final   <= n_final;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= i_sample;
        end
        r_rd_data <= mem[r_addr];
    end

    cma_div #(
        .NUM_W (NUM_W),
        .DIV_W (PTR_W)
    ) u_cma_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_div   (PTR_W'({r_h, 1'b1})),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;
    assign o_final_res = r_final;

endmodule

>>> sv/cma_div.sv
// Bit-serial signed divider with floor rounding, one quotient bit per cycle.
module cma_div #(
    parameter int NUM_W = 30,
    parameter int DIV_W = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DIV_W-1:0] i_div,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [NUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [NUM_W-1:0] r_q;

    logic [DIV_W:0]   trial;
    logic             fits;
    logic [DIV_W:0]   diff;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_quo <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_rem <= '0;
            r_div <= i_div;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
        // floor: a negative quotient with a remainder drops by one
        if (r_fix) begin
            if (!r_neg) begin
                r_q <= r_quo;
            end else if (r_rem != '0) begin
                r_q <= ~r_quo;
            end else begin
                r_q <= -r_quo;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = signed'(r_q);

endmodule

>>> sv/cma_checker.sv
// Port-level checks for the centered moving average, bound to the top level.
module cma_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_average,
    input logic        o_final_res
);

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_average)
            && $stable(o_final_res))
        else $error("stalled result changed");

    // drop the result register on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a record end always starts a flush, so input stalls right after
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> !o_in_ready)
        else $error("item taken during flush");

    // a taken item needs time, so no result rises right after it
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result rose right after item");

endmodule

bind centered_moving_average cma_port_checks u_cma_port_checks (.*);
